// ----- hdl/mrfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrfr_pkg
// shared types, codes and the bytewise crc-16/modbus update for the frame
// receiver
// ----------------------------------------------------------------------------
package mrfr_pkg;

  // event codes on the result channel
  localparam logic [1:0] EV_PAYLOAD  = 2'd0;
  localparam logic [1:0] EV_GOOD     = 2'd1;
  localparam logic [1:0] EV_BAD      = 2'd2;

  // crc-16/modbus
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  // accepted device ids
  localparam logic [7:0] ID_1        = 8'h01;
  localparam logic [7:0] ID_2        = 8'h02;
  localparam logic [7:0] ID_3        = 8'h03;
  localparam logic [7:0] ID_4        = 8'h04;
  localparam logic [7:0] ID_8        = 8'h08;

  // accepted function codes
  localparam logic [7:0] FN_READ_COILS   = 8'h01;
  localparam logic [7:0] FN_READ_HOLD    = 8'h03;
  localparam logic [7:0] FN_WRITE_COIL   = 8'h05;
  localparam logic [7:0] FN_WRITE_REG    = 8'h06;
  localparam logic [7:0] FN_WRITE_COILS  = 8'h0F;

  // parser phase, one-hot
  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_FUNC = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CHK1 = 6'b010000,
    PH_CHK2 = 6'b100000
  } phase_t;

  // one result item
  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] frame_device;
    logic [7:0] frame_function;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
  } res_t;

  // one byte through the reflected crc, a bit per step
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/mrfr_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrfr_parser
// input byte register, frame state and running crc; one parser step per
// registered byte, producing at most one result item
// ----------------------------------------------------------------------------
module mrfr_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_rx_byte,
  input  wire logic             res_ready,
  output logic                  res_valid,
  output mrfr_pkg::res_t        res
);
  import mrfr_pkg::*;

  logic        byte_valid_r, byte_valid_nxt;
  logic [7:0]  byte_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  chk1_r, chk1_nxt;
  logic        step;
  logic        in_take;
  logic [7:0]  count_inc;
  logic [15:0] crc_byte;
  logic        res_hit;
  res_t        res_d;

  // the held byte moves on once the output side has room
  assign in_stall  = byte_valid_r && !res_ready;
  assign in_take   = in_valid && !in_stall;
  assign step      = byte_valid_r && res_ready;
  assign count_inc = count_r + 8'd1;
  assign crc_byte  = crc_feed(crc_r, byte_r);

  always_comb begin
    if (in_take) begin
      byte_valid_nxt = 1'b1;
    end else if (step) begin
      byte_valid_nxt = 1'b0;
    end else begin
      byte_valid_nxt = byte_valid_r;
    end
  end

  // one parser step on the held byte
  always_comb begin
    phase_nxt = phase_r;
    dev_nxt   = dev_r;
    func_nxt  = func_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    crc_nxt   = crc_r;
    chk1_nxt  = chk1_r;
    res_hit   = 1'b0;
    res_d     = '{event_kind: EV_PAYLOAD, frame_device: dev_r, frame_function: func_r,
                  frame_length: len_r, payload_byte: 8'h00, payload_index: 8'h00};
    case (phase_r)
      PH_FUNC: begin
        if (byte_r inside {FN_READ_COILS, FN_READ_HOLD, FN_WRITE_COIL, FN_WRITE_REG,
                           FN_WRITE_COILS}) begin
          func_nxt  = byte_r;
          crc_nxt   = crc_byte;
          phase_nxt = PH_LEN;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LEN: begin
        len_nxt   = byte_r;
        crc_nxt   = crc_byte;
        count_nxt = 8'h00;
        phase_nxt = (byte_r == 8'h00) ? PH_CHK1 : PH_DATA;
      end
      PH_DATA: begin
        crc_nxt             = crc_byte;
        res_hit             = 1'b1;
        res_d.payload_byte  = byte_r;
        res_d.payload_index = count_r;
        count_nxt           = count_inc;
        if (count_inc >= len_r) begin
          phase_nxt = PH_CHK1;
        end
      end
      PH_CHK1: begin
        chk1_nxt  = byte_r;
        phase_nxt = PH_CHK2;
      end
      PH_CHK2: begin
        res_hit          = 1'b1;
        res_d.event_kind = ({byte_r, chk1_r} == crc_r) ? EV_GOOD : EV_BAD;
        phase_nxt        = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (byte_r inside {ID_1, ID_2, ID_3, ID_4, ID_8}) begin
          dev_nxt   = byte_r;
          crc_nxt   = crc_feed(CRC_INIT, byte_r);
          phase_nxt = PH_FUNC;
        end
      end
    endcase
  end

  assign res_valid = step && res_hit;
  assign res       = res_d;

  // input byte register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else begin
      byte_valid_r <= byte_valid_nxt;
    end
    if (in_take) begin
      byte_r <= in_rx_byte;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      dev_r   <= 8'h00;
      func_r  <= 8'h00;
      len_r   <= 8'h00;
      count_r <= 8'h00;
      crc_r   <= CRC_INIT;
      chk1_r  <= 8'h00;
    end else if (step) begin
      phase_r <= phase_nxt;
      dev_r   <= dev_nxt;
      func_r  <= func_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      chk1_r  <= chk1_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mrfr_out_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrfr_out_buf
// result register with a skid stage, so one more result can land while the
// output is stalled
// ----------------------------------------------------------------------------
module mrfr_out_buf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  input  wire mrfr_pkg::res_t   push_data,
  output logic                  push_ready,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output mrfr_pkg::res_t        out_data
);
  import mrfr_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign pop        = out_valid_r && !out_stall;
  assign push_ready = !skid_valid_r;

  // next state of the two slots
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (push_valid) begin
      if (!out_valid_r || pop) begin
        out_nxt       = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- hdl/modbus_rtu_frame_receiver_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_top
// Modbus RTU frame receiver with running CRC-16/MODBUS check.
//
// Input channel: one received byte per transfer on in_rx_byte (in_valid /
// in_stall). Result channel: one transfer per payload byte and one verdict
// (good or check failed) after the second check byte (out_valid /
// out_stall). Header bytes and the first check byte give no result.
// A taken byte is held in the input byte register, then its result is
// registered in the result register. Throughput: one byte per cycle while
// in_stall is low, set by the single crc and parser step between the input
// byte register and the result register.
// Reset (rst_n low, synchronous) empties both registers and the skid slot and
// returns the parser to hunting for a device id with the crc at 0xFFFF.
// When out_stall is high a skid slot takes one more result; after that
// in_stall rises and the held input byte waits until the output drains.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_event_kind,
  output logic [7:0]      out_frame_device,
  output logic [7:0]      out_frame_function,
  output logic [7:0]      out_frame_length,
  output logic [7:0]      out_payload_byte,
  output logic [7:0]      out_payload_index
);
  import mrfr_pkg::*;

  logic res_valid;
  logic res_ready;
  res_t res;
  res_t out_data;

  // parser step
  mrfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register and skid
  mrfr_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_data  (res),
    .push_ready (res_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign out_event_kind     = out_data.event_kind;
  assign out_frame_device   = out_data.frame_device;
  assign out_frame_function = out_data.frame_function;
  assign out_frame_length   = out_data.frame_length;
  assign out_payload_byte   = out_data.payload_byte;
  assign out_payload_index  = out_data.payload_index;

endmodule
`default_nettype wire
